>>> sv/ray_sphere_nearest_hit_top_defines.svh
// Assertion macros for the ray/sphere nearest-hit unit
`ifndef RAY_SPHERE_NEAREST_HIT_TOP_DEFINES_SVH
`define RAY_SPHERE_NEAREST_HIT_TOP_DEFINES_SVH

// check a same-cycle implication on aclk, off during reset
`define RSNH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// check a next-cycle implication on aclk, off during reset
`define RSNH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/rsnh_pkg.sv
// Shared types and constants for the ray/sphere nearest-hit unit
package rsnh_pkg;

    localparam int COORD_W = 32;
    localparam int LEN_W   = 31;
    localparam int TOL_W   = 16;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [LEN_W-1:0] RADIUS_RESET = 31'h0001_0000;
    localparam logic [TOL_W-1:0] TOL_RESET    = 16'd66;

    localparam logic REG_RADIUS = 1'b0;
    localparam logic REG_TOL    = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t             start_x;
        coord_t             start_y;
        coord_t             start_z;
        coord_t             dir_x;
        coord_t             dir_y;
        coord_t             dir_z;
        logic [LEN_W-1:0]   ray_length;
        coord_t             center_x;
        coord_t             center_y;
        coord_t             center_z;
    } rsnh_in_t;

    typedef struct packed {
        logic   hit;
        coord_t hit_x;
        coord_t hit_y;
        coord_t hit_z;
    } rsnh_out_t;

endpackage

>>> sv/ray_sphere_nearest_hit_top.sv
// Ray/sphere nearest-hit pipeline with APB register port
//
//  channel   direction  handshake             payload
//  s_        in         s_valid / s_ready     rsnh_in_t  (one ray and sphere center)
//  m_        out        m_valid / m_ready     rsnh_out_t (hit flag and hit point)
//  apb       in         psel/penable/pready   radius, hit_tolerance
//
//  One request enters per cycle unless a held result stalls the pipeline.
//  Latency is set by the bit-serial stages: two 32-step square roots, a 35-step
//  and three parallel 32-step divisions, one stage per bit.
//  Reset is synchronous, active low, clears the stage valid bits and loads both registers with their reset values.
//  A held result stalls the whole pipeline; nothing is dropped or repeated.
`include "ray_sphere_nearest_hit_top_defines.svh"

module ray_sphere_nearest_hit_top
    import rsnh_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rsnh_in_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rsnh_out_t         m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int SQRT_STEPS = 32;
    localparam int TC_STEPS   = 35;
    localparam int PT_STEPS   = 32;

    localparam int ST_MUL = 1;
    localparam int ST_SUM = ST_MUL + 1;
    localparam int ST_SQA = ST_SUM + 1;
    localparam int ST_DVA = ST_SQA + SQRT_STEPS;
    localparam int ST_DVS = ST_DVA + 1;
    localparam int ST_TC  = ST_DVS + TC_STEPS;
    localparam int ST_P2  = ST_TC + 1;
    localparam int ST_H2  = ST_P2 + 1;
    localparam int ST_SQH = ST_H2 + 1;
    localparam int ST_T12 = ST_SQH + SQRT_STEPS;
    localparam int ST_ABS = ST_T12 + 1;
    localparam int ST_SEL = ST_ABS + 1;
    localparam int ST_PM  = ST_SEL + 1;
    localparam int ST_PDV = ST_PM + 1;
    localparam int ST_PDS = ST_PDV + 1;
    localparam int ST_ADD = ST_PDS + PT_STEPS;
    localparam int ST_SAT = ST_ADD + 1;
    localparam int LAST   = ST_SAT;

    typedef struct packed {
        coord_t [2:0]       s;
        coord_t [2:0]       d;
        logic [LEN_W-1:0]   len;
        logic [2:0][32:0]   mv;
        logic [2:0][65:0]   dd;
        logic [2:0][65:0]   md;
        logic [2:0][65:0]   mm;
        logic [66:0]        b;
        logic [65:0]        m;
        logic               dzero;
        logic [63:0]        sq_v;
        logic [31:0]        sq_root;
        logic [34:0]        sq_rem;
        logic [31:0]        n;
        logic [34:0]        dv_num;
        logic [31:0]        dv_rem;
        logic [34:0]        dv_quo;
        logic               dv_neg;
        logic signed [35:0] tc;
        logic [69:0]        tc2;
        logic [65:0]        p2;
        logic               pass;
        logic signed [36:0] t1;
        logic signed [36:0] t2;
        logic [36:0]        d1;
        logic [36:0]        d2;
        logic               hit;
        logic signed [31:0] t;
        logic [2:0][63:0]   pt;
        logic [2:0]         pneg;
        logic [2:0][31:0]   pnum;
        logic [2:0][31:0]   prem;
        logic [2:0][31:0]   pquo;
        logic [2:0][33:0]   sum;
        coord_t [2:0]       hp;
    } ctx_t;

    logic [LEN_W-1:0] radius_reg;
    logic [TOL_W-1:0] tol_reg;
    logic [61:0]      r2_reg;
    logic [63:0]      lim2_reg;
    logic [31:0]      rt;
    logic             pipe_en;
    logic [LAST:0]    vld_reg;
    ctx_t             ctx_reg  [0:LAST];
    ctx_t             ctx_next [1:LAST];

    function automatic logic signed [65:0] smul(input logic signed [32:0] x,
                                                input logic signed [32:0] y);
        logic signed [65:0] xe;
        logic signed [65:0] ye;
        xe = {{33{x[32]}}, x};
        ye = {{33{y[32]}}, y};
        return xe * ye;
    endfunction

    function automatic logic signed [67:0] ext68(input logic [65:0] v);
        return {{2{v[65]}}, v};
    endfunction

    function automatic logic [32:0] diff33(input coord_t a, input coord_t b);
        logic signed [32:0] ae;
        logic signed [32:0] be;
        ae = {a[31], a};
        be = {b[31], b};
        return ae - be;
    endfunction

    function automatic ctx_t load_fn(input rsnh_in_t r);
        ctx_t c;
        c       = '0;
        c.s[0]  = r.start_x;
        c.s[1]  = r.start_y;
        c.s[2]  = r.start_z;
        c.d[0]  = r.dir_x;
        c.d[1]  = r.dir_y;
        c.d[2]  = r.dir_z;
        c.len   = r.ray_length;
        c.mv[0] = diff33(r.center_x, r.start_x);
        c.mv[1] = diff33(r.center_y, r.start_y);
        c.mv[2] = diff33(r.center_z, r.start_z);
        return c;
    endfunction

    function automatic ctx_t mul_fn(input ctx_t ci);
        ctx_t c;
        logic signed [32:0] de;
        logic signed [32:0] me;
        c = ci;
        for (int i = 0; i < 3; i++) begin
            de       = $signed({c.d[i][31], c.d[i]});
            me       = $signed(c.mv[i]);
            c.dd[i]  = smul(de, de);
            c.md[i]  = smul(me, de);
            c.mm[i]  = smul(me, me);
        end
        return c;
    endfunction

    function automatic ctx_t sum_fn(input ctx_t ci);
        ctx_t c;
        logic signed [67:0] sa;
        logic signed [67:0] sb;
        logic signed [67:0] sm;
        c  = ci;
        sa = ext68(c.dd[0]) + ext68(c.dd[1]) + ext68(c.dd[2]);
        sb = ext68(c.md[0]) + ext68(c.md[1]) + ext68(c.md[2]);
        sm = ext68(c.mm[0]) + ext68(c.mm[1]) + ext68(c.mm[2]);
        c.b       = sb[66:0];
        c.m       = sm[65:0];
        c.dzero   = (sa == '0);
        c.sq_v    = sa[63:0];
        c.sq_root = '0;
        c.sq_rem  = '0;
        return c;
    endfunction

    function automatic ctx_t sqrt_fn(input ctx_t ci);
        ctx_t c;
        logic [34:0] r;
        logic [34:0] trial;
        c     = ci;
        r     = {c.sq_rem[32:0], c.sq_v[63:62]};
        trial = {1'b0, c.sq_root, 2'b01};
        if (r >= trial) begin
            c.sq_rem  = r - trial;
            c.sq_root = {c.sq_root[30:0], 1'b1};
        end else begin
            c.sq_rem  = r;
            c.sq_root = {c.sq_root[30:0], 1'b0};
        end
        c.sq_v = {c.sq_v[61:0], 2'b00};
        return c;
    endfunction

    function automatic ctx_t dva_fn(input ctx_t ci);
        ctx_t c;
        logic signed [66:0] bs;
        logic [66:0]        mag;
        c        = ci;
        bs       = $signed(c.b);
        mag      = bs[66] ? -bs : bs;
        c.n      = c.sq_root;
        c.dv_neg = bs[66];
        c.dv_rem = mag[66:35];
        c.dv_num = mag[34:0];
        c.dv_quo = '0;
        return c;
    endfunction

    function automatic ctx_t dvs_fn(input ctx_t ci);
        ctx_t c;
        logic [32:0] r;
        logic        q;
        c = ci;
        r = {c.dv_rem, c.dv_num[34]};
        q = (r >= {1'b0, c.n});
        if (q) begin
            r = r - {1'b0, c.n};
        end
        c.dv_rem = r[31:0];
        c.dv_num = {c.dv_num[33:0], 1'b0};
        c.dv_quo = {c.dv_quo[33:0], q};
        return c;
    endfunction

    function automatic ctx_t tc_fn(input ctx_t ci);
        ctx_t c;
        logic [69:0]        qe;
        logic signed [35:0] qs;
        c    = ci;
        qe   = {35'b0, c.dv_quo};
        qs   = $signed({1'b0, c.dv_quo});
        c.tc2 = qe * qe;
        c.tc  = c.dv_neg ? -qs : qs;
        return c;
    endfunction

    function automatic ctx_t p2_fn(input ctx_t ci);
        ctx_t c;
        logic [69:0] me;
        logic [69:0] df;
        c    = ci;
        me   = {4'b0, c.m};
        df   = me - c.tc2;
        c.p2 = (c.tc2 > me) ? '0 : df[65:0];
        return c;
    endfunction

    function automatic ctx_t h2_fn(input ctx_t ci, input logic [61:0] r2,
                                   input logic [63:0] lim2);
        ctx_t c;
        logic [65:0] r2e;
        logic [65:0] df;
        c         = ci;
        r2e       = {4'b0, r2};
        df        = (r2e >= c.p2) ? r2e - c.p2 : c.p2 - r2e;
        c.pass    = (c.p2 <= {2'b00, lim2});
        c.sq_v    = df[63:0];
        c.sq_root = '0;
        c.sq_rem  = '0;
        return c;
    endfunction

    function automatic ctx_t t12_fn(input ctx_t ci);
        ctx_t c;
        logic signed [36:0] te;
        logic signed [36:0] he;
        c    = ci;
        te   = {c.tc[35], c.tc};
        he   = $signed({5'b0, c.sq_root});
        c.t1 = te + he;
        c.t2 = te - he;
        return c;
    endfunction

    function automatic ctx_t abs_fn(input ctx_t ci);
        ctx_t c;
        c    = ci;
        c.d1 = c.t1[36] ? -c.t1 : c.t1;
        c.d2 = c.t2[36] ? -c.t2 : c.t2;
        return c;
    endfunction

    function automatic ctx_t sel_fn(input ctx_t ci);
        ctx_t c;
        logic [36:0] le;
        logic        ok;
        c  = ci;
        le = {6'b0, c.len};
        ok = !c.dzero && c.pass;
        if (ok && (c.d1 > c.d2) && (c.d2 < le)) begin
            c.hit = 1'b1;
            c.t   = c.t2[31:0];
        end else if (ok && (c.d1 < le)) begin
            c.hit = 1'b1;
            c.t   = c.t1[31:0];
        end else begin
            c.hit = 1'b0;
            c.t   = '0;
        end
        return c;
    endfunction

    function automatic ctx_t pm_fn(input ctx_t ci);
        ctx_t c;
        logic signed [63:0] de;
        logic signed [63:0] te;
        c  = ci;
        te = {{32{c.t[31]}}, c.t};
        for (int i = 0; i < 3; i++) begin
            de      = {{32{c.d[i][31]}}, c.d[i]};
            c.pt[i] = de * te;
        end
        return c;
    endfunction

    function automatic ctx_t pdv_fn(input ctx_t ci);
        ctx_t c;
        logic signed [63:0] ps;
        logic [63:0]        pm;
        c = ci;
        for (int i = 0; i < 3; i++) begin
            ps        = $signed(c.pt[i]);
            pm        = ps[63] ? -ps : ps;
            c.pneg[i] = ps[63];
            c.prem[i] = {2'b00, pm[61:32]};
            c.pnum[i] = pm[31:0];
            c.pquo[i] = '0;
        end
        return c;
    endfunction

    function automatic ctx_t pds_fn(input ctx_t ci);
        ctx_t c;
        logic [32:0] r;
        logic        q;
        c = ci;
        for (int i = 0; i < 3; i++) begin
            r = {c.prem[i], c.pnum[i][31]};
            q = (r >= {1'b0, c.n});
            if (q) begin
                r = r - {1'b0, c.n};
            end
            c.prem[i] = r[31:0];
            c.pnum[i] = {c.pnum[i][30:0], 1'b0};
            c.pquo[i] = {c.pquo[i][30:0], q};
        end
        return c;
    endfunction

    function automatic ctx_t add_fn(input ctx_t ci);
        ctx_t c;
        logic signed [33:0] se;
        logic signed [33:0] oe;
        c = ci;
        for (int i = 0; i < 3; i++) begin
            se       = {{2{c.s[i][31]}}, c.s[i]};
            oe       = $signed({2'b00, c.pquo[i]});
            c.sum[i] = c.pneg[i] ? se - oe : se + oe;
        end
        return c;
    endfunction

    function automatic ctx_t sat_fn(input ctx_t ci);
        ctx_t c;
        logic [33:0] v;
        c = ci;
        for (int i = 0; i < 3; i++) begin
            v = c.sum[i];
            if (!c.hit) begin
                c.hp[i] = '0;
            end else if ((v[33:31] == 3'b000) || (v[33:31] == 3'b111)) begin
                c.hp[i] = v[31:0];
            end else if (v[33]) begin
                c.hp[i] = {1'b1, {(COORD_W-1){1'b0}}};
            end else begin
                c.hp[i] = {1'b0, {(COORD_W-1){1'b1}}};
            end
        end
        return c;
    endfunction

    function automatic ctx_t stage_fn(input int k, input ctx_t c, input logic [61:0] r2,
                                      input logic [63:0] lim2);
        if (k == ST_MUL) begin
            return mul_fn(c);
        end else if (k == ST_SUM) begin
            return sum_fn(c);
        end else if (k >= ST_SQA && k < ST_DVA) begin
            return sqrt_fn(c);
        end else if (k == ST_DVA) begin
            return dva_fn(c);
        end else if (k >= ST_DVS && k < ST_TC) begin
            return dvs_fn(c);
        end else if (k == ST_TC) begin
            return tc_fn(c);
        end else if (k == ST_P2) begin
            return p2_fn(c);
        end else if (k == ST_H2) begin
            return h2_fn(c, r2, lim2);
        end else if (k >= ST_SQH && k < ST_T12) begin
            return sqrt_fn(c);
        end else if (k == ST_T12) begin
            return t12_fn(c);
        end else if (k == ST_ABS) begin
            return abs_fn(c);
        end else if (k == ST_SEL) begin
            return sel_fn(c);
        end else if (k == ST_PM) begin
            return pm_fn(c);
        end else if (k == ST_PDV) begin
            return pdv_fn(c);
        end else if (k >= ST_PDS && k < ST_ADD) begin
            return pds_fn(c);
        end else if (k == ST_ADD) begin
            return add_fn(c);
        end else begin
            return sat_fn(c);
        end
    endfunction

    // configuration registers
    assign pready = 1'b1;
    assign rt     = {1'b0, radius_reg} + {{(32-TOL_W){1'b0}}, tol_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RADIUS_RESET;
            tol_reg    <= TOL_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                REG_RADIUS: radius_reg <= pwdata[LEN_W-1:0];
                REG_TOL:    tol_reg    <= pwdata[TOL_W-1:0];
                default:    radius_reg <= radius_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_RADIUS: prdata = {1'b0, radius_reg};
            REG_TOL:    prdata = {{(APB_DW-TOL_W){1'b0}}, tol_reg};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        r2_reg   <= {31'b0, radius_reg} * {31'b0, radius_reg};
        lim2_reg <= {32'b0, rt} * {32'b0, rt};
    end

    // pipeline
    assign pipe_en = !vld_reg[LAST] || m_ready;
    assign s_ready = pipe_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (pipe_en) begin
            vld_reg <= {vld_reg[LAST-1:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            ctx_reg[0] <= load_fn(s_data);
        end
    end

    for (genvar k = 1; k <= LAST; k++) begin : g_stage
        always_comb begin
            ctx_next[k] = stage_fn(k, ctx_reg[k-1], r2_reg, lim2_reg);
        end

        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                ctx_reg[k] <= ctx_next[k];
            end
        end
    end

    assign m_valid      = vld_reg[LAST];
    assign m_data.hit   = ctx_reg[LAST].hit;
    assign m_data.hit_x = ctx_reg[LAST].hp[0];
    assign m_data.hit_y = ctx_reg[LAST].hp[1];
    assign m_data.hit_z = ctx_reg[LAST].hp[2];

    `RSNH_ASSERT_NOW(a_miss_zero, m_valid && !m_data.hit, (m_data.hit_x == 0) && (m_data.hit_y == 0) && (m_data.hit_z == 0), "miss result carries nonzero point")
    `RSNH_ASSERT_NEXT(a_stall_hold, !pipe_en, vld_reg == $past(vld_reg), "stage valids moved during stall")
    `RSNH_ASSERT_NOW(a_div_bound, vld_reg[ST_DVA] && !ctx_reg[ST_DVA].dzero, ctx_reg[ST_DVA].dv_rem < ctx_reg[ST_DVA].n, "projection quotient exceeds its width")
    `RSNH_ASSERT_NOW(a_sqrt_rem, vld_reg[ST_DVA-1], ctx_reg[ST_DVA-1].sq_rem <= {2'b00, ctx_reg[ST_DVA-1].sq_root, 1'b0}, "square root remainder out of range")

endmodule
